@@ hdl/deq_pkg.sv @@
// Shared types and constants of the double-ended queue unit.
// Depends on nothing; every other file of the unit imports it.
package deq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CMD_W-1:0]          t_cmd;
    typedef logic [STATUS_W-1:0]       t_status;

    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_READ_FWD   = 3'd4;
    localparam t_cmd CMD_READ_BWD   = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        K_PUSH,
        K_POP,
        K_READ
    } t_kind;

    // One classified command as it waits between the front and back parts.
    typedef struct packed {
        t_kind  kind;
        logic   at_back;
        t_value data;
    } t_item;

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_FILL_W = $clog2(CMDQ_DEPTH + 1);

endpackage

@@ hdl/deq_ifs.sv @@
// Channel interfaces of the double-ended queue unit: commands in, results out.
// Depends on deq_pkg.
interface deq_in_if;
    import deq_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   command;
    t_value data_value;

    modport source (output valid, output command, output data_value, input ready);
    modport sink   (input valid, input command, input data_value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic    valid;
    logic    ready;
    t_value  out_value;
    t_status status;
    logic    last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

@@ hdl/deq_front.sv @@
// Front part: accepts command transactions and classifies them into queue items.
// Depends on deq_pkg and deq_in_if.
module deq_front (
    deq_in_if.sink         i_cmd,
    output logic           o_push_valid,
    output deq_pkg::t_item o_push_item,
    input  logic           i_push_ready
);
    import deq_pkg::*;

    logic w_known;

    assign i_cmd.ready = i_push_ready;

    always_comb begin
        w_known             = 1'b1;
        o_push_item.kind    = K_PUSH;
        o_push_item.at_back = 1'b0;
        o_push_item.data    = i_cmd.data_value;
        case (i_cmd.command)
            CMD_PUSH_FRONT: begin
                o_push_item.kind = K_PUSH;
            end
            CMD_PUSH_BACK: begin
                o_push_item.kind    = K_PUSH;
                o_push_item.at_back = 1'b1;
            end
            CMD_POP_FRONT: begin
                o_push_item.kind = K_POP;
            end
            CMD_POP_BACK: begin
                o_push_item.kind    = K_POP;
                o_push_item.at_back = 1'b1;
            end
            CMD_READ_FWD: begin
                o_push_item.kind = K_READ;
            end
            CMD_READ_BWD: begin
                o_push_item.kind    = K_READ;
                o_push_item.at_back = 1'b1;
            end
            default: begin
                // Unused codes are consumed and produce nothing.
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push_valid = i_cmd.valid && w_known;

endmodule

@@ hdl/deq_cmd_fifo.sv @@
// Short command queue between the front and back parts.
// Depends on deq_pkg.
module deq_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  deq_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output deq_pkg::t_item o_pop_item,
    input  logic           i_pop
);
    import deq_pkg::*;

    t_item                  r_slots [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CMDQ_FILL_W-1:0] r_fill, n_fill;
    logic                   w_push;
    logic                   w_pop;

    assign o_push_ready = (r_fill != CMDQ_FILL_W'(CMDQ_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_item   = r_slots[r_rd_ptr];

    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ hdl/deq_back.sv @@
// Back part: carries out queued commands on the ring store and drives results.
// Depends on deq_pkg and deq_out_if.
module deq_back #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  deq_pkg::t_item i_item,
    output logic           o_item_take,
    deq_out_if.source      o_res
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_bwd, n_bwd;
    logic            r_out_valid, n_out_valid;
    t_value          r_out_value, n_out_value;
    t_status         r_out_status, n_out_status;
    logic            r_out_last, n_out_last;

    t_value          r_store [DEPTH];
    t_value          r_rd_data;

    logic            w_slot;
    logic            w_take;
    logic            w_full;
    logic            w_empty;
    logic [CW-1:0]   w_cnt_m1;
    logic [AW-1:0]   w_front_dec;
    logic [AW-1:0]   w_front_inc;
    logic [AW-1:0]   w_back_pos;
    logic [AW-1:0]   w_back_last;
    logic [AW-1:0]   w_scan_off;
    logic [AW-1:0]   w_scan_addr;
    logic            w_scan_last;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;

    // Position base + off on the ring; both operands are below DEPTH.
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign w_slot   = !r_out_valid || o_res.ready;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_cnt_m1 = r_count - 1'b1;

    assign w_front_dec = ring_pos(r_front, AW'(DEPTH - 1));
    assign w_front_inc = ring_pos(r_front, AW'(1));
    assign w_back_pos  = ring_pos(r_front, r_count[AW-1:0]);
    assign w_back_last = ring_pos(r_front, w_cnt_m1[AW-1:0]);
    assign w_scan_off  = r_bwd ? (w_cnt_m1[AW-1:0] - r_idx) : r_idx;
    assign w_scan_addr = ring_pos(r_front, w_scan_off);
    assign w_scan_last = (r_idx == w_cnt_m1[AW-1:0]);

    assign o_item_take     = w_take;
    assign o_res.valid     = r_out_valid;
    assign o_res.out_value = r_out_value;
    assign o_res.status    = r_out_status;
    assign o_res.last      = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_bwd        = r_bwd;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_take       = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = w_back_pos;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_front;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid && w_slot) begin
                    w_take = 1'b1;
                    case (i_item.kind)
                        K_PUSH: begin
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            if (w_full) begin
                                n_out_value  = '0;
                                n_out_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                if (!i_item.at_back) begin
                                    n_front   = w_front_dec;
                                    w_wr_addr = w_front_dec;
                                end
                                n_count      = r_count + 1'b1;
                                n_out_value  = i_item.data;
                                n_out_status = ST_OK;
                            end
                        end
                        K_POP: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_value  = '0;
                                n_out_status = ST_EMPTY;
                                n_out_last   = 1'b1;
                            end else begin
                                w_rd_en = 1'b1;
                                if (i_item.at_back) begin
                                    w_rd_addr = w_back_last;
                                end else begin
                                    n_front = w_front_inc;
                                end
                                n_count = w_cnt_m1;
                                n_state = S_POP_WAIT;
                            end
                        end
                        K_READ: begin
                            if (w_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_value  = '0;
                                n_out_status = ST_EMPTY;
                                n_out_last   = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_bwd   = i_item.at_back;
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_rd_data;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_scan_addr;
                n_state   = S_SCAN_OUT;
            end
            S_SCAN_OUT: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_rd_data;
                    n_out_status = ST_OK;
                    n_out_last   = w_scan_last;
                    if (w_scan_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_bwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_bwd       <= n_bwd;
            r_out_valid <= n_out_valid;
        end
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_store[w_rd_addr];
        end
    end

    a_ring_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_front} < DEPTH_W) && (r_count <= CW'(DEPTH)))
        else $error("front pointer or entry count out of range");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_item.kind == K_PUSH && !w_full)
        |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("accepted push did not add one entry");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT && w_slot)
        |=> (r_out_valid && r_out_status == ST_OK && r_out_last && r_state == S_IDLE))
        else $error("pop did not deliver a single final result");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_OUT && w_slot && w_scan_last)
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("read-out did not end on its marked final result");

endmodule

@@ hdl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue unit: front classifier, command queue, back engine.
// Depends on deq_pkg, deq_ifs, deq_front, deq_cmd_fifo and deq_back.
//
// Usage: commands arrive on i_cmd_ch (valid/ready, command and data_value) and
// results leave on o_res_ch (valid/ready, out_value, status and last). Each
// command yields one result, except a read-out of a non-empty queue, which
// yields one result per stored entry with last set on the final one. Unused
// command codes are taken and yield nothing.
// A two-entry command queue sits between the classifier and the engine, so
// commands keep being taken while the engine works or a result waits.
// A push or an empty/full answer passes the command queue and then the result
// register; a pop also passes the registered read port of the entry store, and a
// read-out reads each entry through that port before it is sent.
// Sustained rate: one push per cycle while the receiver takes results; the engine
// takes no new command while a pop or a read-out is in progress.
// Reset empties the queue (front pointer and count to zero); stored values are
// not cleared and need no clearing pass. When the receiver holds ready low,
// the result register holds its transaction, the engine waits, and once the
// command queue fills i_cmd_ch.ready falls.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_cmd_ch,
    deq_out_if.source o_res_ch
);
    import deq_pkg::*;

    logic  w_push_valid;
    t_item w_push_item;
    logic  w_push_ready;
    logic  w_pop_valid;
    t_item w_pop_item;
    logic  w_pop;

    deq_front u_front (
        .i_cmd        (i_cmd_ch),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item),
        .i_push_ready (w_push_ready)
    );

    deq_cmd_fifo u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop        (w_pop)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_pop_valid),
        .i_item       (w_pop_item),
        .o_item_take  (w_pop),
        .o_res        (o_res_ch)
    );

endmodule
